// ===== design/crer_pkg.sv =====
package crer_pkg;

    localparam int XY_W       = 7;
    localparam int ENERGY_W   = 20;
    localparam int GAIN_W     = 16;
    localparam int CLUSTER_W  = 24;
    localparam int RAW_W      = 28;
    localparam int CAL_W      = 44;
    localparam int WPROD_W    = ENERGY_W + GAIN_W;
    localparam int CAL_HALF_W = CAL_W / 2;
    localparam int PROD_W     = CLUSTER_W + CAL_W;
    localparam int FRAC_W     = 14;
    localparam int QUO_W      = CLUSTER_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int DIST_W     = 17;

    localparam logic [XY_W-1:0]      TABLE_OFFSET = 7'd30;
    localparam logic [DIST_W-1:0]    RING_INNER   = 17'd529;
    localparam logic [DIST_W-1:0]    RING_OUTER   = 17'd1369;
    localparam logic signed [8:0]    RING_CENTER2 = 9'sd101;
    localparam logic [GAIN_W-1:0]    GAIN_ONE     = 16'd16384;
    localparam logic [RAW_W-1:0]     RAW_MAX      = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0]     CAL_MAX      = {CAL_W{1'b1}};
    localparam logic [CLUSTER_W-1:0] OUT_MAX      = {CLUSTER_W{1'b1}};
    localparam logic [CNT_W-1:0]     CNT_LAST     = CNT_W'(DIV_STEPS - 1);

    localparam logic KIND_LOAD = 1'b0;

    typedef struct packed {
        logic capture;
        logic mem_write;
        logic mem_read;
        logic accumulate;
        logic mul_lo;
        logic mul_hi;
        logic sat_check;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic last_hit;
        logic raw_zero;
        logic sat;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== design/crer_ctrl.sv =====
module crer_ctrl
    import crer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_WRITE   = 9'b000000010,
        S_READ    = 9'b000000100,
        S_ACC     = 9'b000001000,
        S_MUL_LO  = 9'b000010000,
        S_MUL_HI  = 9'b000100000,
        S_SAT_CHK = 9'b001000000,
        S_DIV     = 9'b010000000,
        S_FINISH  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                // loads reuse this slot to decode, then write next cycle
                if (i_status.is_load) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.mem_read = 1'b1;
                    n_state        = S_ACC;
                end
            end
            S_WRITE: begin
                o_cmd.mem_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_ACC: begin
                o_cmd.accumulate = 1'b1;
                n_state          = i_status.last_hit ? S_MUL_LO : S_IDLE;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = i_status.raw_zero ? S_FINISH : S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SAT_CHK;
            end
            S_SAT_CHK: begin
                o_cmd.sat_check = 1'b1;
                n_state         = i_status.sat ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/crer_dpath.sv =====
module crer_dpath
    import crer_pkg::*;
#(
    parameter int TABLE_SPAN = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_kind,
    input  logic                 i_endcap_side,
    input  logic [XY_W-1:0]      i_crystal_x,
    input  logic [XY_W-1:0]      i_crystal_y,
    input  logic [ENERGY_W-1:0]  i_hit_energy,
    input  logic [GAIN_W-1:0]    i_gain_value,
    input  logic [CLUSTER_W-1:0] i_cluster_energy,
    input  logic                 i_last_hit,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CLUSTER_W-1:0] o_corrected_energy,
    output logic                 o_no_energy_flag,
    output logic                 o_saturated_flag
);

    localparam int SIDE_SIZE = TABLE_SPAN * TABLE_SPAN;
    localparam int DEPTH     = 2 * SIDE_SIZE;
    localparam int ADDR_W    = $clog2(DEPTH);

    // captured word
    logic                 r_kind;
    logic                 r_side;
    logic [XY_W-1:0]      r_x;
    logic [XY_W-1:0]      r_y;
    logic [ENERGY_W-1:0]  r_energy;
    logic [GAIN_W-1:0]    r_gain;
    logic [CLUSTER_W-1:0] r_cluster;
    logic                 r_last;

    logic [GAIN_W-1:0]    mem [DEPTH];
    logic [GAIN_W-1:0]    r_rdata;
    logic                 r_use_table;

    logic [RAW_W-1:0]     r_raw;
    logic [CAL_W-1:0]     r_cal;
    logic [PROD_W-1:0]    r_prod;
    logic [RAW_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_sat;

    logic                 r_out_valid;
    logic [CLUSTER_W-1:0] r_out_energy;
    logic                 r_out_none;
    logic                 r_out_sat;

    logic [XY_W-1:0]      xo;
    logic [XY_W-1:0]      yo;
    logic                 in_table;
    logic [ADDR_W-1:0]    addr;
    logic signed [8:0]    dx;
    logic signed [8:0]    dy;
    logic signed [17:0]   dx_sq;
    logic signed [17:0]   dy_sq;
    logic [DIST_W-1:0]    rad_sq;
    logic                 in_ring;

    logic [GAIN_W-1:0]    weight;
    logic [WPROD_W-1:0]   wprod;
    logic [RAW_W:0]       raw_sum;
    logic [CAL_W:0]       cal_sum;
    logic [PROD_W-1:0]    part_hi;
    logic [PROD_W-FRAC_W-1:0] scaled;
    logic [RAW_W:0]       rem_sh;
    logic                 q_bit;

    // table decode
    assign xo       = r_x - TABLE_OFFSET;
    assign yo       = r_y - TABLE_OFFSET;
    assign in_table = (r_x >= TABLE_OFFSET) && (r_y >= TABLE_OFFSET)
                   && (xo < XY_W'(TABLE_SPAN)) && (yo < XY_W'(TABLE_SPAN));
    assign addr     = ADDR_W'(r_side) * ADDR_W'(SIDE_SIZE)
                    + ADDR_W'(xo) * ADDR_W'(TABLE_SPAN) + ADDR_W'(yo);

    // annulus test on doubled coordinates
    assign dx      = $signed({1'b0, r_x, 1'b0}) - RING_CENTER2;
    assign dy      = $signed({1'b0, r_y, 1'b0}) - RING_CENTER2;
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign rad_sq  = DIST_W'(dx_sq) + DIST_W'(dy_sq);
    assign in_ring = (rad_sq >= RING_INNER) && (rad_sq <= RING_OUTER);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_kind;
            r_side    <= i_endcap_side;
            r_x       <= i_crystal_x;
            r_y       <= i_crystal_y;
            r_energy  <= i_hit_energy;
            r_gain    <= i_gain_value;
            r_cluster <= i_cluster_energy;
            r_last    <= i_last_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write && in_table) begin
            mem[addr] <= r_gain;
        end
        if (i_cmd.mem_read) begin
            r_rdata     <= mem[addr];
            r_use_table <= in_ring && in_table;
        end
    end

    // accumulate, saturating
    assign weight  = r_use_table ? r_rdata : GAIN_ONE;
    assign wprod   = r_energy * weight;
    assign raw_sum = {1'b0, r_raw} + (RAW_W + 1)'(r_energy);
    assign cal_sum = {1'b0, r_cal} + (CAL_W + 1)'(wprod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= '0;
            r_cal <= '0;
        end else if (i_cmd.accumulate) begin
            r_raw <= raw_sum[RAW_W] ? RAW_MAX : raw_sum[RAW_W-1:0];
            r_cal <= cal_sum[CAL_W] ? CAL_MAX : cal_sum[CAL_W-1:0];
        end else if (i_cmd.finish) begin
            r_raw <= '0;
            r_cal <= '0;
        end
    end

    // cluster * cal in two partial products, then drop the Q.14 scale
    assign part_hi = PROD_W'(r_cluster * r_cal[CAL_W-1:CAL_HALF_W]) << CAL_HALF_W;
    assign scaled  = r_prod[PROD_W-1:FRAC_W];

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[QUO_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_raw});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(r_cluster * r_cal[CAL_HALF_W-1:0]);
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + part_hi;
        end
        if (i_cmd.mul_lo) begin
            r_sat <= 1'b0;
        end else if (i_cmd.sat_check) begin
            r_sat <= o_status.sat;
            r_rem <= RAW_W'(scaled[PROD_W-FRAC_W-1:QUO_W]);
            r_quo <= scaled[QUO_W-1:0];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? RAW_W'(rem_sh - {1'b0, r_raw}) : rem_sh[RAW_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            priority if (r_raw == '0) begin
                r_out_energy <= r_cluster;
                r_out_none   <= 1'b1;
                r_out_sat    <= 1'b0;
            end else if (r_sat) begin
                r_out_energy <= OUT_MAX;
                r_out_none   <= 1'b0;
                r_out_sat    <= 1'b1;
            end else begin
                r_out_energy <= r_quo;
                r_out_none   <= 1'b0;
                r_out_sat    <= 1'b0;
            end
        end
    end

    assign o_status.is_load  = (r_kind == KIND_LOAD);
    assign o_status.last_hit = r_last;
    assign o_status.raw_zero = (r_raw == '0);
    assign o_status.sat      = ((PROD_W - FRAC_W - QUO_W)'(r_raw)
                                <= scaled[PROD_W-FRAC_W-1:QUO_W]);
    assign o_status.div_done = (r_cnt == CNT_LAST);
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid            = r_out_valid;
    assign o_corrected_energy = r_out_energy;
    assign o_no_energy_flag   = r_out_none;
    assign o_saturated_flag   = r_out_sat;

endmodule

// ===== design/calorimeter_ring_energy_recalibration.sv =====
// Endcap ring recalibration of one cluster. Load words (kind 0) write a gain
// per side and crystal into an on-chip table of 2*TABLE_SPAN^2 Q2.14 entries;
// hit words (kind 1) sum the raw energy and the gain-weighted energy, where
// only crystals inside the calibrated annulus use their table gain. The word
// marked last_hit yields one result: cluster_energy * calibrated / raw,
// truncated and clipped to 24 bits, or the cluster energy with
// no_energy_flag when the raw sum is zero; both sums then clear. Gains must be
// loaded before any annulus crystal is hit. One word is in work at a time: a
// load or a hit is accepted, decoded with its table access, then does the
// table write or the multiply-accumulate. A last hit adds the multiply, a
// saturation check and a restoring divider with one quotient bit per cycle,
// skipped on saturation or a zero raw sum. A finished result
// sits in an output register, so new words are taken while it waits.
module calorimeter_ring_energy_recalibration
    import crer_pkg::*;
#(
    parameter int TABLE_SPAN = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic                 i_endcap_side,
    input  logic [XY_W-1:0]      i_crystal_x,
    input  logic [XY_W-1:0]      i_crystal_y,
    input  logic [ENERGY_W-1:0]  i_hit_energy,
    input  logic [GAIN_W-1:0]    i_gain_value,
    input  logic [CLUSTER_W-1:0] i_cluster_energy,
    input  logic                 i_last_hit,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CLUSTER_W-1:0] o_corrected_energy,
    output logic                 o_no_energy_flag,
    output logic                 o_saturated_flag
);

    t_cmd    cmd;
    t_status status;

    crer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    crer_dpath #(
        .TABLE_SPAN (TABLE_SPAN)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_kind             (i_kind),
        .i_endcap_side      (i_endcap_side),
        .i_crystal_x        (i_crystal_x),
        .i_crystal_y        (i_crystal_y),
        .i_hit_energy       (i_hit_energy),
        .i_gain_value       (i_gain_value),
        .i_cluster_energy   (i_cluster_energy),
        .i_last_hit         (i_last_hit),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_corrected_energy (o_corrected_energy),
        .o_no_energy_flag   (o_no_energy_flag),
        .o_saturated_flag   (o_saturated_flag)
    );

endmodule

// ===== tb/sv/recal_energy_checker.sv =====
`timescale 1ns / 100ps

module recal_energy_checker
    import crer_pkg::*;
#(
    parameter int TABLE_SPAN = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_kind,
    input  logic                 i_endcap_side,
    input  logic [XY_W-1:0]      i_crystal_x,
    input  logic [XY_W-1:0]      i_crystal_y,
    input  logic [ENERGY_W-1:0]  i_hit_energy,
    input  logic [GAIN_W-1:0]    i_gain_value,
    input  logic [CLUSTER_W-1:0] i_cluster_energy,
    input  logic                 i_last_hit,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [CLUSTER_W-1:0] i_corrected_energy,
    input  logic                 i_no_energy_flag,
    input  logic                 i_saturated_flag,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_results
);

    localparam int TABLE_BASE  = 30;
    localparam int GAIN_FRAC   = 14;
    localparam int CENTRE_X2   = 101;
    localparam int RING_LO_SQ4 = 529;
    localparam int RING_HI_SQ4 = 1369;
    localparam logic [GAIN_W-1:0] UNIT_WEIGHT = 16'd16384;

    typedef struct packed {
        logic [CLUSTER_W-1:0] energy;
        logic                 no_energy;
        logic                 saturated;
    } t_recal_result;

    logic [GAIN_W-1:0] gain_mem [2*TABLE_SPAN*TABLE_SPAN];
    logic [RAW_W-1:0]  raw_sum;
    logic [CAL_W-1:0]  cal_sum;
    t_recal_result     recal_q[$];
    int                mismatches = 0;
    int                results = 0;

    assign o_mismatches = mismatches;
    assign o_results    = results;

    // Fold one accepted word into the gain table or the cluster sums.
    task automatic absorb_word();
        int                col;
        int                row;
        int                slot;
        int                dx;
        int                dy;
        bit                in_table;
        bit                in_ring;
        logic [GAIN_W-1:0] weight;
        logic [RAW_W:0]    raw_next;
        logic [CAL_W:0]    cal_next;
        logic [PROD_W-1:0] quotient;
        t_recal_result     r;
        col      = int'(i_crystal_x) - TABLE_BASE;
        row      = int'(i_crystal_y) - TABLE_BASE;
        in_table = col >= 0 && col < TABLE_SPAN && row >= 0 && row < TABLE_SPAN;
        slot     = int'(i_endcap_side) * TABLE_SPAN * TABLE_SPAN + col * TABLE_SPAN + row;
        if (i_kind == KIND_LOAD) begin
            if (in_table)
                gain_mem[slot] = i_gain_value;
        end else begin
            dx       = 2 * int'(i_crystal_x) - CENTRE_X2;
            dy       = 2 * int'(i_crystal_y) - CENTRE_X2;
            in_ring  = (dx * dx + dy * dy >= RING_LO_SQ4) && (dx * dx + dy * dy <= RING_HI_SQ4);
            weight   = (in_ring && in_table) ? gain_mem[slot] : UNIT_WEIGHT;
            raw_next = raw_sum + i_hit_energy;
            cal_next = cal_sum + i_hit_energy * weight;
            raw_sum  = raw_next[RAW_W] ? '1 : raw_next[RAW_W-1:0];
            cal_sum  = cal_next[CAL_W] ? '1 : cal_next[CAL_W-1:0];
            if (i_last_hit) begin
                if (raw_sum == '0) begin
                    r.energy    = i_cluster_energy;
                    r.no_energy = 1'b1;
                    r.saturated = 1'b0;
                end else begin
                    quotient = (PROD_W'(i_cluster_energy) * PROD_W'(cal_sum))
                             / (PROD_W'(raw_sum) << GAIN_FRAC);
                    r.saturated = (quotient >> CLUSTER_W) != '0;
                    r.energy    = r.saturated ? '1 : quotient[CLUSTER_W-1:0];
                    r.no_energy = 1'b0;
                end
                recal_q = {recal_q, r};
                raw_sum = '0;
                cal_sum = '0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_recal_result want;
        if (!i_rst_n) begin
            recal_q.delete();
            raw_sum = '0;
            cal_sum = '0;
        end else begin
            // Check the outgoing word first: a word taken at this edge cannot produce it.
            if (i_out_valid && i_out_ready) begin
                if (recal_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: energy %0d no_energy %0b saturated %0b",
                                 i_corrected_energy, i_no_energy_flag, i_saturated_flag);
                end else begin
                    want = recal_q.pop_front();
                    results++;
                    if (i_corrected_energy !== want.energy
                            || i_no_energy_flag !== want.no_energy
                            || i_saturated_flag !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: expected energy %0d no_energy %0b ",
                                      "saturated %0b, got energy %0d no_energy %0b saturated %0b"},
                                     results, want.energy, want.no_energy, want.saturated,
                                     i_corrected_energy, i_no_energy_flag, i_saturated_flag);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_word();
        end
        o_pending <= recal_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import crer_pkg::*;

    localparam int   TABLE_SPAN      = 40;
    localparam int   TABLE_BASE      = 30;
    localparam int   WORD_TARGET     = 1900;
    localparam int   QUIET_TAIL      = 150;
    localparam int   HOLD_OFF_AT     = 700;
    localparam int   HOLD_OFF_CYCLES = 400;
    localparam int   LONG_AT         = 1100;
    localparam int   LONG_HITS       = 300;
    localparam int   DRAIN_CYCLES    = 64;
    localparam int   STALL_LIMIT     = 3000;
    localparam logic KIND_HIT        = ~KIND_LOAD;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic                 endcap_side;
    logic [XY_W-1:0]      crystal_x;
    logic [XY_W-1:0]      crystal_y;
    logic [ENERGY_W-1:0]  hit_energy;
    logic [GAIN_W-1:0]    gain_value;
    logic [CLUSTER_W-1:0] cluster_energy;
    logic                 last_hit;
    logic                 out_valid;
    logic                 out_ready;
    logic [CLUSTER_W-1:0] corrected_energy;
    logic                 no_energy_flag;
    logic                 saturated_flag;

    int mismatches;
    int expected_left;
    int results_seen;

    bit gain_loaded [2][128][128];
    int words_sent = 0;
    int loads_sent = 0;
    int hits_sent = 0;
    int send_idle_odds = 0;
    int take_idle_odds = 0;
    bit hold_off_req = 1'b0;
    int quiet_cycles = 0;

    calorimeter_ring_energy_recalibration #(
        .TABLE_SPAN(TABLE_SPAN)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_kind(kind),
        .i_endcap_side(endcap_side),
        .i_crystal_x(crystal_x),
        .i_crystal_y(crystal_y),
        .i_hit_energy(hit_energy),
        .i_gain_value(gain_value),
        .i_cluster_energy(cluster_energy),
        .i_last_hit(last_hit),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_corrected_energy(corrected_energy),
        .o_no_energy_flag(no_energy_flag),
        .o_saturated_flag(saturated_flag)
    );

    recal_energy_checker #(
        .TABLE_SPAN(TABLE_SPAN)
    ) recal_chk (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_ready(in_ready),
        .i_kind(kind),
        .i_endcap_side(endcap_side),
        .i_crystal_x(crystal_x),
        .i_crystal_y(crystal_y),
        .i_hit_energy(hit_energy),
        .i_gain_value(gain_value),
        .i_cluster_energy(cluster_energy),
        .i_last_hit(last_hit),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_corrected_energy(corrected_energy),
        .i_no_energy_flag(no_energy_flag),
        .i_saturated_flag(saturated_flag),
        .o_mismatches(mismatches),
        .o_pending(expected_left),
        .o_results(results_seen)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [ENERGY_W-1:0] rand_energy();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ENERGY_W'($urandom_range(1, 255));
            default: return ENERGY_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_ONE;
            3:       return GAIN_ONE + GAIN_W'($urandom_range(0, 2048)) - GAIN_W'(1024);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [CLUSTER_W-1:0] rand_cluster();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return CLUSTER_W'($urandom_range(1, 4095));
            default: return CLUSTER_W'($urandom);
        endcase
    endfunction

    function automatic bit in_gain_table(logic [XY_W-1:0] x, logic [XY_W-1:0] y);
        return x >= TABLE_BASE && x < TABLE_BASE + TABLE_SPAN
            && y >= TABLE_BASE && y < TABLE_BASE + TABLE_SPAN;
    endfunction

    // Mostly the ring region, then the nominal face, the full field range and the table rim.
    task automatic pick_crystal(output logic [XY_W-1:0] x, output logic [XY_W-1:0] y);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                x = XY_W'($urandom_range(32, 69));
                y = XY_W'($urandom_range(32, 69));
            end
            5, 6, 7: begin
                x = XY_W'($urandom_range(1, 100));
                y = XY_W'($urandom_range(1, 100));
            end
            8: begin
                x = XY_W'($urandom_range(0, 127));
                y = XY_W'($urandom_range(0, 127));
            end
            default: begin
                x = XY_W'($urandom_range(25, 75));
                y = XY_W'($urandom_range(25, 75));
            end
        endcase
    endtask

    task automatic send_word(input logic k, input logic s,
                             input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic [ENERGY_W-1:0] e, input logic [GAIN_W-1:0] g,
                             input logic [CLUSTER_W-1:0] c, input logic l);
        if (send_idle_odds != 0 && $urandom_range(0, 7) < send_idle_odds) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        endcap_side    <= s;
        crystal_x      <= x;
        crystal_y      <= y;
        hit_energy     <= e;
        gain_value     <= g;
        cluster_energy <= c;
        last_hit       <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        if (k == KIND_LOAD)
            loads_sent++;
        else
            hits_sent++;
    endtask

    task automatic send_load(input logic s, input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                             input logic [GAIN_W-1:0] g);
        if (in_gain_table(x, y))
            gain_loaded[s][x][y] = 1'b1;
        send_word(KIND_LOAD, s, x, y, rand_energy(), g, rand_cluster(), 1'($urandom_range(0, 1)));
    endtask

    // Load the crystal's gain first if it has never been written.
    task automatic send_hit(input logic s, input logic [XY_W-1:0] x, input logic [XY_W-1:0] y,
                            input logic [ENERGY_W-1:0] e, input logic [CLUSTER_W-1:0] c,
                            input logic l);
        if (in_gain_table(x, y) && !gain_loaded[s][x][y])
            send_load(s, x, y, rand_gain());
        send_word(KIND_HIT, s, x, y, e, rand_gain(), c, l);
    endtask

    task automatic send_cluster(input int n_hits);
        logic            s;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        bit              dead;
        dead = ($urandom_range(0, 19) == 0);
        s    = 1'($urandom_range(0, 1));
        for (int i = 1; i <= n_hits; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                pick_crystal(x, y);
                send_load(1'($urandom_range(0, 1)), x, y, rand_gain());
            end
            pick_crystal(x, y);
            if ($urandom_range(0, 7) == 0)
                s = ~s;
            send_hit(s, x, y, dead ? ENERGY_W'(0) : rand_energy(), rand_cluster(), i == n_hits);
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (take_idle_odds != 0 && $urandom_range(0, 7) < take_idle_odds) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results still due",
                     STALL_LIMIT, expected_left);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        bit hold_off_sent;
        bit long_sent;
        hold_off_sent = 1'b0;
        long_sent     = 1'b0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= KIND_LOAD;
        endcap_side    <= 1'b0;
        crystal_x      <= '0;
        crystal_y      <= '0;
        hit_energy     <= '0;
        gain_value     <= '0;
        cluster_energy <= '0;
        last_hit       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_odds = 2;
        take_idle_odds = 2;
        // gain extremes next to the ring edges; loads off the table are dropped
        send_load(1'b0, 7'd62, 7'd50, '0);
        send_load(1'b1, 7'd68, 7'd56, '1);
        send_load(1'b0, 7'd39, 7'd50, GAIN_ONE);
        send_load(1'b1, 7'd10, 7'd10, '1);
        send_load(1'b0, 7'd0, 7'd0, '1);
        send_load(1'b1, 7'd127, 7'd127, '0);
        // empty raw sum passes the cluster energy through
        send_hit(1'b0, 7'd50, 7'd50, '0, '1, 1'b1);
        // zero gain gives zero energy
        send_hit(1'b0, 7'd62, 7'd50, '1, '1, 1'b1);
        // largest gain on the largest cluster clips
        send_hit(1'b1, 7'd68, 7'd56, '1, '1, 1'b1);
        // crystals just off the ring, and off the face, weigh one
        send_hit(1'b0, 7'd61, 7'd50, 20'd1000, '0, 1'b0);
        send_hit(1'b1, 7'd68, 7'd57, 20'd3000, '0, 1'b0);
        send_hit(1'b0, 7'd0, 7'd0, '1, '0, 1'b0);
        send_hit(1'b1, 7'd127, 7'd127, 20'd5, '0, 1'b0);
        send_hit(1'b0, 7'd1, 7'd100, 20'd77, '0, 1'b0);
        send_hit(1'b0, 7'd39, 7'd50, 20'd4096, '0, 1'b1);
        send_hit(1'b1, 7'd50, 7'd50, '1, 24'hABCDEF, 1'b1);
        send_hit(1'b0, 7'd62, 7'd50, 20'd256, 24'd100000, 1'b0);
        send_hit(1'b1, 7'd68, 7'd56, 20'd256, 24'd100000, 1'b1);

        while (words_sent < WORD_TARGET) begin
            if (words_sent >= WORD_TARGET - QUIET_TAIL) begin
                send_idle_odds = 0;
                take_idle_odds = 0;
            end else begin
                send_idle_odds = $urandom_range(0, 3);
                take_idle_odds = $urandom_range(0, 3);
            end
            if (!hold_off_sent && words_sent >= HOLD_OFF_AT) begin
                hold_off_req  = 1'b1;
                hold_off_sent = 1'b1;
            end
            if (!long_sent && words_sent >= LONG_AT) begin
                // drive both sums into saturation with one long cluster
                long_sent = 1'b1;
                send_load(1'b1, 7'd68, 7'd56, '1);
                for (int i = 1; i <= LONG_HITS; i++)
                    send_hit(1'b1, 7'd68, 7'd56, '1, rand_cluster(), i == LONG_HITS);
            end else if ($urandom_range(0, 9) == 0) begin
                logic [XY_W-1:0] nx;
                logic [XY_W-1:0] ny;
                pick_crystal(nx, ny);
                send_load(1'($urandom_range(0, 1)), nx, ny, rand_gain());
            end else begin
                send_cluster(($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                         : $urandom_range(1, 6));
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        wait (expected_left == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d words: %0d gain loads, %0d hits, %0d cluster results checked",
                 words_sent, loads_sent, hits_sent, results_seen);
        $display("ring edges, zero gain, clipping, empty clusters, %0d-hit saturating cluster",
                 LONG_HITS);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/crer_pkg.sv
design/crer_ctrl.sv
design/crer_dpath.sv
design/calorimeter_ring_energy_recalibration.sv
tb/sv/recal_energy_checker.sv
tb/sv/tb_top.sv
